[sv/compacting_key_table_assert.svh]
// Assertion macros used by the checker file of the key table.
`ifndef COMPACTING_KEY_TABLE_ASSERT_SVH
`define COMPACTING_KEY_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define CKT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("key table check failed");

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define CKT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("key table check failed");

`endif

[sv/cktbl_pkg.sv]
// Package: types, opcodes and default sizes of the compacting key table.
`timescale 1ns / 1ps
`default_nettype none

package cktbl_pkg;

    localparam int DEF_CAPACITY     = 64;
    localparam int DEF_KEY_BITS     = 16;
    localparam int DEF_PAYLOAD_BITS = 32;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

[sv/compacting_key_table.sv]
// Top level of the compacting key table: entry memory, scan sequencer, result register.
//
//   channel  direction  handshake            fields
//   -------  ---------  -------------------  -------------------------------------
//   in       to block   in_valid / in_stall  opcode, key, payload_in
//   out      from block out_valid / out_stall hit, payload_out, status, occupancy
//
// One item in flight. An add, a refused add, the unused opcode and an empty-table scan go
// straight to the response state; a scan reads one slot per cycle behind the registered
// read, and a remove that moves the last entry adds a move read and a move write. The
// single read port sets this pace.
// Reset clears only the count and control state; slots at or above the count are never compared.
// in_stall is high while an item is in progress; a stalled result waits in the response state.
`timescale 1ns / 1ps
`default_nettype none

module compacting_key_table #(
    parameter int CAPACITY     = cktbl_pkg::DEF_CAPACITY,
    parameter int KEY_BITS     = cktbl_pkg::DEF_KEY_BITS,
    parameter int PAYLOAD_BITS = cktbl_pkg::DEF_PAYLOAD_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [1:0]                        opcode,
    input  wire logic [KEY_BITS-1:0]               key,
    input  wire logic [PAYLOAD_BITS-1:0]           payload_in,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   hit,
    output logic [PAYLOAD_BITS-1:0]                payload_out,
    output logic                                   status,
    output logic [$clog2(CAPACITY+1)-1:0]          occupancy
);
    import cktbl_pkg::*;

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int ENTRY_W = KEY_BITS + PAYLOAD_BITS;

    // Entry memory: key in the upper bits, payload in the lower bits.
    logic [ENTRY_W-1:0]      table_mem [CAPACITY];
    logic [ENTRY_W-1:0]      rd_data_reg;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [ENTRY_W-1:0]      wr_data;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [1:0]              op_reg, op_next;
    logic [KEY_BITS-1:0]     key_reg, key_next;
    logic [CNT_W-1:0]        issue_reg, issue_next;
    logic                    chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]        chk_idx_reg, chk_idx_next;
    logic [IDX_W-1:0]        found_reg, found_next;
    logic                    res_hit_reg, res_hit_next;
    logic [PAYLOAD_BITS-1:0] res_pay_reg, res_pay_next;
    logic                    res_status_reg, res_status_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_hit_reg, out_hit_next;
    logic [PAYLOAD_BITS-1:0] out_pay_reg, out_pay_next;
    logic                    out_status_reg, out_status_next;
    logic [CNT_W-1:0]        out_occ_reg, out_occ_next;

    logic [CNT_W-1:0]        last_cnt;
    logic [IDX_W-1:0]        last_idx;
    logic                    full;
    logic                    key_match;
    logic                    out_free;

    // Memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    assign last_cnt  = count_reg - CNT_W'(1);
    assign last_idx  = last_cnt[IDX_W-1:0];
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign key_match = (rd_data_reg[ENTRY_W-1:PAYLOAD_BITS] == key_reg);
    assign out_free  = !out_valid_reg || !out_stall;

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign hit         = out_hit_reg;
    assign payload_out = out_pay_reg;
    assign status      = out_status_reg;
    assign occupancy   = out_occ_reg;

    // Control state and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            chk_vld_reg   <= chk_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and index registers.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        issue_reg      <= issue_next;
        chk_idx_reg    <= chk_idx_next;
        found_reg      <= found_next;
        res_hit_reg    <= res_hit_next;
        res_pay_reg    <= res_pay_next;
        res_status_reg <= res_status_next;
        out_hit_reg    <= out_hit_next;
        out_pay_reg    <= out_pay_next;
        out_status_reg <= out_status_next;
        out_occ_reg    <= out_occ_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        issue_next      = issue_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        found_next      = found_reg;
        res_hit_next    = res_hit_reg;
        res_pay_next    = res_pay_reg;
        res_status_next = res_status_reg;
        out_hit_next    = out_hit_reg;
        out_pay_next    = out_pay_reg;
        out_status_next = out_status_reg;
        out_occ_next    = out_occ_reg;
        rd_en           = 1'b0;
        rd_addr         = issue_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = count_reg[IDX_W-1:0];
        wr_data         = {key_reg, payload_in};

        // Drop the result once the consumer takes it.
        out_valid_next  = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = opcode;
                    key_next        = key;
                    issue_next      = '0;
                    res_hit_next    = 1'b0;
                    res_pay_next    = '0;
                    res_status_next = 1'b0;
                    state_next      = ST_RESP;
                    unique case (op_t'(opcode))
                        OP_ADD:
                        begin
                            // Append at the end, or refuse when every slot is taken.
                            if (full)
                            begin
                                res_status_next = 1'b1;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_data    = {key, payload_in};
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_LOOKUP, OP_REMOVE:
                        begin
                            // An empty table misses without touching memory.
                            if (count_reg != '0)
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // Issue one read per cycle; compare the slot read the cycle before.
                rd_en        = 1'b1;
                issue_next   = issue_reg + CNT_W'(1);
                chk_vld_next = 1'b1;
                chk_idx_next = issue_reg[IDX_W-1:0];
                if (chk_vld_reg)
                begin
                    if (key_match)
                    begin
                        chk_vld_next = 1'b0;
                        res_hit_next = 1'b1;
                        if (op_reg == OP_LOOKUP)
                        begin
                            res_pay_next = rd_data_reg[PAYLOAD_BITS-1:0];
                            state_next   = ST_RESP;
                        end
                        else if (chk_idx_reg == last_idx)
                        begin
                            // Last entry removed: shrink the count only.
                            count_next = last_cnt;
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            found_next = chk_idx_reg;
                            state_next = ST_MOVE_RD;
                        end
                    end
                    else if (chk_idx_reg == last_idx)
                    begin
                        chk_vld_next = 1'b0;
                        state_next   = ST_RESP;
                    end
                end
            end

            ST_MOVE_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = last_idx;
                state_next = ST_MOVE_WR;
            end

            ST_MOVE_WR:
            begin
                // Fill the hole with the last entry and shrink the count.
                wr_en      = 1'b1;
                wr_addr    = found_reg;
                wr_data    = rd_data_reg;
                count_next = last_cnt;
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                // Hold until the result register is free, then load it.
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_hit_next    = res_hit_reg;
                    out_pay_next    = res_pay_reg;
                    out_status_next = res_status_reg;
                    out_occ_next    = count_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/cktbl_checker.sv]
// Port-level checker of the compacting key table and its bind.
`timescale 1ns / 1ps
`default_nettype none

`include "compacting_key_table_assert.svh"

module cktbl_checker #(
    parameter int CAPACITY     = cktbl_pkg::DEF_CAPACITY,
    parameter int PAYLOAD_BITS = cktbl_pkg::DEF_PAYLOAD_BITS
) (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         out_valid,
    input wire logic                         out_stall,
    input wire logic                         hit,
    input wire logic [PAYLOAD_BITS-1:0]      payload_out,
    input wire logic                         status,
    input wire logic [$clog2(CAPACITY+1)-1:0] occupancy
);
    import cktbl_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // A stalled result stays offered.
    `CKT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    // Occupancy never exceeds the table size.
    `CKT_ASSERT_NOW(a_occ_range, out_valid, occupancy <= CNT_W'(CAPACITY))
    // A refused add only happens on a full table and reports no hit.
    `CKT_ASSERT_NOW(a_full_refuse, out_valid && status,
                    occupancy == CNT_W'(CAPACITY) && !hit)
    // Payload is only returned together with a hit.
    `CKT_ASSERT_NOW(a_miss_zero, out_valid && !hit, payload_out == '0)

endmodule

bind compacting_key_table cktbl_checker #(
    .CAPACITY     (CAPACITY),
    .PAYLOAD_BITS (PAYLOAD_BITS)
) u_cktbl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .payload_out (payload_out),
    .status      (status),
    .occupancy   (occupancy)
);

`default_nettype wire
